// ----- hdl/psa_pkg.sv -----
package psa_pkg;

    // Held test outcome.
    typedef enum logic [1:0] {
        VERDICT_RUNNING      = 2'd0,
        VERDICT_H1           = 2'd1,
        VERDICT_H0           = 2'd2,
        VERDICT_INCONCLUSIVE = 2'd3
    } verdict_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_H0_PAIR_SCORE   = 3'd0,
        REG_H1_PAIR_SCORE   = 3'd1,
        REG_ACCEPT_BOUND    = 3'd2,
        REG_REJECT_BOUND    = 3'd3,
        REG_REPORT_INTERVAL = 3'd4,
        REG_PAIR_CAP        = 3'd5
    } cfg_reg_t;

    // Port and register widths.
    localparam int INDEX_W    = 3;
    localparam int DATA_W     = 32;
    localparam int SCORE_W    = 18;
    localparam int BOUND_W    = 32;
    localparam int INTERVAL_W = 16;
    localparam int CAP_W      = 20;
    localparam int LLR_W      = 32;
    localparam int PAIRS_W    = 20;

    // Number of pentanomial bins.
    localparam int BUCKETS = 5;

    // Fixed-point layout of the intermediate values.
    localparam int MU_W        = 18;
    localparam int MU_SHIFT    = 15;
    localparam int VAR_SHIFT   = 14;
    localparam int VAR_W       = 17;
    localparam int DELTA_MAG_W = 18;
    localparam int DEV_MAG_W   = 19;
    localparam int PROD_W      = DELTA_MAG_W + DEV_MAG_W;

    localparam logic [VAR_W-1:0]         VAR_MAX = 17'd65536;
    localparam logic signed [LLR_W-1:0]  LLR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [LLR_W-1:0]  LLR_MIN = 32'sh8000_0000;

    // Register values after reset.
    localparam logic [SCORE_W-1:0]         H0_RESET       = 18'd65536;
    localparam logic [SCORE_W-1:0]         H1_RESET       = 18'd66479;
    localparam logic signed [BOUND_W-1:0]  ACCEPT_RESET   = 32'sd192941;
    localparam logic signed [BOUND_W-1:0]  REJECT_RESET   = -32'sd192941;
    localparam logic [INTERVAL_W-1:0]      INTERVAL_RESET = 16'd16;
    localparam logic [CAP_W-1:0]           CAP_RESET      = 20'd20000;

    // Half points of one game: win 2, draw 1, loss (either negative code) 0.
    function automatic logic [2:0] result_points(input logic [1:0] code);
        logic [2:0] pts;
        unique case (code)
            2'b01:   pts = 3'd2;
            2'b00:   pts = 3'd1;
            default: pts = 3'd0;
        endcase
        return pts;
    endfunction

    // Square of a bin index, for the second moment.
    function automatic logic [4:0] bucket_square(input logic [2:0] k);
        logic [4:0] sq;
        unique case (k)
            3'd0:    sq = 5'd0;
            3'd1:    sq = 5'd1;
            3'd2:    sq = 5'd4;
            3'd3:    sq = 5'd9;
            3'd4:    sq = 5'd16;
            default: sq = 5'd0;
        endcase
        return sq;
    endfunction

endpackage

// ----- hdl/pentanomial_sprt_accumulator.sv -----
// Channel   Direction  Handshake                   Payload
// cfg       in         cfg_valid / cfg_ready       cfg_index, cfg_data
// pair      in         pair_valid / pair_ready     first_result, second_result
// result    out        result_valid / result_ready verdict, evaluated, llr_value, pairs_seen
//
// A pair that triggers no evaluation goes from S_CHECK to S_DONE (straight to S_DONE
// once a verdict is held). An evaluating pair runs eight multiply and divide passes,
// one bit per cycle, through a single shared adder.
// Reset clears the bins, sums, held verdict and LLR and loads the default registers.
// A new pair is taken while an earlier result still waits; a stalled result only
// holds the sequencer at its last step. The cfg channel is always ready.
module pentanomial_sprt_accumulator #(
    parameter int COUNT_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [psa_pkg::INDEX_W-1:0] cfg_index,
    input  logic [psa_pkg::DATA_W-1:0]  cfg_data,
    input  logic                        pair_valid,
    output logic                        pair_ready,
    input  logic signed [1:0]           first_result,
    input  logic signed [1:0]           second_result,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [1:0]                  verdict,
    output logic                        evaluated,
    output logic signed [psa_pkg::LLR_W-1:0] llr_value,
    output logic [psa_pkg::PAIRS_W-1:0] pairs_seen
);
    import psa_pkg::*;

    // Widths that follow from the bin counter size.
    localparam int N_W     = COUNT_BITS + 3;
    localparam int S1_W    = COUNT_BITS + 5;
    localparam int S2_W    = COUNT_BITS + 7;
    localparam int NN_W    = 2 * N_W;
    localparam int P_W     = N_W + S2_W;
    localparam int MU_K    = S1_W + MU_SHIFT;
    localparam int VAR_K   = P_W + VAR_SHIFT;
    localparam int NUM_K   = N_W + PROD_W;
    localparam int DW      = (VAR_K > NUM_K) ? VAR_K : NUM_K;
    localparam int CNT_W   = $clog2(DW + 1);
    localparam int CMP_W   = ((N_W > CAP_W) ? N_W : CAP_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_RUN,
        S_NEXT,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_MU,
        OP_NN,
        OP_P1,
        OP_P2,
        OP_VAR,
        OP_PROD,
        OP_NUM,
        OP_LLR
    } op_t;

    state_t                     state_reg;
    op_t                        op_reg;
    op_t                        op_after;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           op_len;

    // Configuration registers.
    logic [SCORE_W-1:0]         h0_reg;
    logic [SCORE_W-1:0]         h1_reg;
    logic signed [BOUND_W-1:0]  accept_reg;
    logic signed [BOUND_W-1:0]  reject_reg;
    logic [INTERVAL_W-1:0]      interval_reg;
    logic [CAP_W-1:0]           cap_reg;

    // Test state.
    logic [COUNT_BITS-1:0]      bin_reg [BUCKETS];
    logic [N_W-1:0]             n_reg;
    logic [S1_W-1:0]            s1_reg;
    logic [S2_W-1:0]            s2_reg;
    logic [N_W-1:0]             last_eval_reg;
    verdict_t                   held_verdict_reg;
    logic signed [LLR_W-1:0]    held_llr_reg;
    logic                       eval_flag_reg;

    // Output register.
    logic                       result_valid_reg;
    logic [1:0]                 verdict_reg;
    logic                       evaluated_reg;
    logic signed [LLR_W-1:0]    llr_reg;
    logic [PAIRS_W-1:0]         pairs_reg;

    // Shared unit and intermediate values.
    logic [DW-1:0]              acc_reg;
    logic [DW-1:0]              shr_reg;
    logic [DW-1:0]              opd_reg;
    logic                       is_div_reg;
    logic [MU_W-1:0]            mu_reg;
    logic [NN_W-1:0]            nn_reg;
    logic [P_W-1:0]             p1_reg;
    logic [VAR_W-1:0]           var_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       neg_reg;

    logic [2:0]                 bucket;
    logic                       bin_full;
    logic                       cap_reached;
    logic                       eval_due;
    logic [P_W-1:0]             t_diff;
    logic signed [SCORE_W:0]    delta;
    logic signed [SCORE_W+1:0]  dev;
    logic [SCORE_W:0]           delta_abs;
    logic [SCORE_W+1:0]         dev_abs;
    logic [DW+1:0]              unit_a;
    logic [DW+1:0]              unit_b;
    logic [DW+1:0]              unit_y;
    logic                       q_bit;
    logic [DW-1:0]              acc_next;
    logic [DW-1:0]              shr_next;
    logic [VAR_W-1:0]           var_clamped;
    logic                       llr_over;
    logic signed [LLR_W-1:0]    llr_sat;
    verdict_t                   llr_verdict;

    assign cfg_ready    = 1'b1;
    assign pair_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign verdict      = verdict_reg;
    assign evaluated    = evaluated_reg;
    assign llr_value    = llr_reg;
    assign pairs_seen   = pairs_reg;

    // Bin selection for the incoming pair.
    assign bucket   = result_points(first_result) + result_points(second_result);
    assign bin_full = &bin_reg[bucket];

    // Evaluation trigger: interval elapsed or cap reached.
    assign cap_reached = CMP_W'(n_reg) >= CMP_W'(cap_reg);
    assign eval_due    = (n_reg != '0) &&
                         ((CMP_W'(n_reg) >= CMP_W'(last_eval_reg) + CMP_W'(interval_reg)) ||
                          cap_reached);

    // Numerator of the variance, from the two stored products.
    assign t_diff = p1_reg - acc_reg[P_W-1:0];

    // Signed terms of the LLR and their magnitudes.
    assign delta     = $signed({1'b0, h1_reg}) - $signed({1'b0, h0_reg});
    assign dev       = $signed({1'b0, mu_reg, 1'b0}) - $signed({2'b00, h0_reg})
                       - $signed({2'b00, h1_reg});
    assign delta_abs = delta[SCORE_W] ? (~delta + 1'b1) : delta;
    assign dev_abs   = dev[SCORE_W+1] ? (~dev + 1'b1) : dev;

    // Pass length of each operation.
    always_comb
    begin
        unique case (op_reg)
            OP_MU:   op_len = CNT_W'(MU_K);
            OP_NN:   op_len = CNT_W'(N_W);
            OP_P1:   op_len = CNT_W'(N_W);
            OP_P2:   op_len = CNT_W'(S1_W);
            OP_VAR:  op_len = CNT_W'(VAR_K);
            OP_PROD: op_len = CNT_W'(DELTA_MAG_W);
            OP_NUM:  op_len = CNT_W'(N_W);
            OP_LLR:  op_len = CNT_W'(NUM_K);
            default: op_len = CNT_W'(DW);
        endcase
    end

    // Operation order.
    always_comb
    begin
        unique case (op_reg)
            OP_MU:   op_after = OP_NN;
            OP_NN:   op_after = OP_P1;
            OP_P1:   op_after = OP_P2;
            OP_P2:   op_after = OP_VAR;
            OP_VAR:  op_after = OP_PROD;
            OP_PROD: op_after = OP_NUM;
            OP_NUM:  op_after = OP_LLR;
            default: op_after = OP_LLR;
        endcase
    end

    // Shared adder: shift-add multiply step or restoring divide step, MSB first.
    assign unit_a   = {1'b0, acc_reg, is_div_reg & shr_reg[DW-1]};
    assign unit_b   = (is_div_reg || shr_reg[DW-1]) ? {2'b00, opd_reg} : '0;
    assign unit_y   = unit_a + (unit_b ^ {(DW+2){is_div_reg}}) + (DW+2)'(is_div_reg);
    assign q_bit    = is_div_reg & ~unit_y[DW+1];
    assign acc_next = (is_div_reg && unit_y[DW+1]) ? unit_a[DW-1:0] : unit_y[DW-1:0];
    assign shr_next = {shr_reg[DW-2:0], q_bit};

    // Variance floored at one LSB and capped at its largest possible value.
    always_comb
    begin
        priority if (shr_reg > DW'(VAR_MAX))
            var_clamped = VAR_MAX;
        else if (shr_reg == '0)
            var_clamped = VAR_W'(1);
        else
            var_clamped = shr_reg[VAR_W-1:0];
    end

    // Signed, saturated LLR from the final quotient.
    assign llr_over = |shr_reg[DW-1:LLR_W-1];
    always_comb
    begin
        if (neg_reg)
            llr_sat = llr_over ? LLR_MIN : $signed(~shr_reg[LLR_W-1:0] + 1'b1);
        else
            llr_sat = llr_over ? LLR_MAX : $signed(shr_reg[LLR_W-1:0]);
    end

    // Decision on the new LLR; accept wins over reject, then the cap ends the test.
    always_comb
    begin
        priority if (llr_sat >= accept_reg)
            llr_verdict = VERDICT_H1;
        else if (llr_sat <= reject_reg)
            llr_verdict = VERDICT_H0;
        else if (cap_reached)
            llr_verdict = VERDICT_INCONCLUSIVE;
        else
            llr_verdict = VERDICT_RUNNING;
    end

    // Sequencer, configuration, test state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_MU;
            cnt_reg          <= '0;
            h0_reg           <= H0_RESET;
            h1_reg           <= H1_RESET;
            accept_reg       <= ACCEPT_RESET;
            reject_reg       <= REJECT_RESET;
            interval_reg     <= INTERVAL_RESET;
            cap_reg          <= CAP_RESET;
            for (int k = 0; k < BUCKETS; k++)
            begin
                bin_reg[k] <= '0;
            end
            n_reg            <= '0;
            s1_reg           <= '0;
            s2_reg           <= '0;
            last_eval_reg    <= '0;
            held_verdict_reg <= VERDICT_RUNNING;
            held_llr_reg     <= '0;
            eval_flag_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            verdict_reg      <= '0;
            evaluated_reg    <= 1'b0;
            llr_reg          <= '0;
            pairs_reg        <= '0;
        end
        else
        begin
            // Register writes; unknown indexes are dropped.
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_H0_PAIR_SCORE:   h0_reg       <= cfg_data[SCORE_W-1:0];
                    REG_H1_PAIR_SCORE:   h1_reg       <= cfg_data[SCORE_W-1:0];
                    REG_ACCEPT_BOUND:    accept_reg   <= $signed(cfg_data[BOUND_W-1:0]);
                    REG_REJECT_BOUND:    reject_reg   <= $signed(cfg_data[BOUND_W-1:0]);
                    REG_REPORT_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                    REG_PAIR_CAP:        cap_reg      <= cfg_data[CAP_W-1:0];
                    default:             ;
                endcase
            end

            // The output register empties unless a new item moves in at the same edge.
            if (result_valid_reg && result_ready && state_reg != S_DONE)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pair_valid)
                    begin
                        if (held_verdict_reg != VERDICT_RUNNING)
                        begin
                            eval_flag_reg <= 1'b0;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            // A full bin drops the pair.
                            if (!bin_full)
                            begin
                                bin_reg[bucket] <= bin_reg[bucket] + COUNT_BITS'(1);
                                n_reg           <= n_reg + N_W'(1);
                                s1_reg          <= s1_reg + S1_W'(bucket);
                                s2_reg          <= s2_reg + S2_W'(bucket_square(bucket));
                            end
                            state_reg <= S_CHECK;
                        end
                    end
                end

                S_CHECK:
                begin
                    if (eval_due)
                    begin
                        last_eval_reg <= n_reg;
                        eval_flag_reg <= 1'b1;
                        op_reg        <= OP_MU;
                        state_reg     <= S_LOAD;
                    end
                    else
                    begin
                        eval_flag_reg <= 1'b0;
                        if (cap_reached)
                        begin
                            held_verdict_reg <= VERDICT_INCONCLUSIVE;
                        end
                        state_reg <= S_DONE;
                    end
                end

                S_LOAD:
                begin
                    cnt_reg   <= op_len;
                    state_reg <= S_RUN;
                end

                S_RUN:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= S_NEXT;
                    end
                end

                S_NEXT:
                begin
                    if (op_reg == OP_LLR)
                    begin
                        held_llr_reg     <= llr_sat;
                        held_verdict_reg <= llr_verdict;
                        state_reg        <= S_DONE;
                    end
                    else
                    begin
                        op_reg    <= op_after;
                        state_reg <= S_LOAD;
                    end
                end

                S_DONE:
                begin
                    if (!result_valid_reg || result_ready)
                    begin
                        result_valid_reg <= 1'b1;
                        verdict_reg      <= held_verdict_reg;
                        evaluated_reg    <= eval_flag_reg;
                        llr_reg          <= held_llr_reg;
                        pairs_reg        <= PAIRS_W'(n_reg);
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Shared unit operands, steps and captured results.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            acc_reg <= '0;
            unique case (op_reg)
                OP_MU:
                begin
                    is_div_reg <= 1'b1;
                    shr_reg    <= DW'({s1_reg, {MU_SHIFT{1'b0}}}) << (DW - MU_K);
                    opd_reg    <= DW'(n_reg);
                end
                OP_NN:
                begin
                    is_div_reg <= 1'b0;
                    shr_reg    <= DW'(n_reg) << (DW - N_W);
                    opd_reg    <= DW'(n_reg);
                end
                OP_P1:
                begin
                    is_div_reg <= 1'b0;
                    shr_reg    <= DW'(n_reg) << (DW - N_W);
                    opd_reg    <= DW'(s2_reg);
                end
                OP_P2:
                begin
                    is_div_reg <= 1'b0;
                    shr_reg    <= DW'(s1_reg) << (DW - S1_W);
                    opd_reg    <= DW'(s1_reg);
                end
                OP_VAR:
                begin
                    is_div_reg <= 1'b1;
                    shr_reg    <= DW'({t_diff, {VAR_SHIFT{1'b0}}}) << (DW - VAR_K);
                    opd_reg    <= DW'(nn_reg);
                end
                OP_PROD:
                begin
                    is_div_reg <= 1'b0;
                    shr_reg    <= DW'(delta_abs[DELTA_MAG_W-1:0]) << (DW - DELTA_MAG_W);
                    opd_reg    <= DW'(dev_abs[DEV_MAG_W-1:0]);
                    neg_reg    <= delta[SCORE_W] ^ dev[SCORE_W+1];
                end
                OP_NUM:
                begin
                    is_div_reg <= 1'b0;
                    shr_reg    <= DW'(n_reg) << (DW - N_W);
                    opd_reg    <= DW'(prod_reg);
                end
                default:
                begin
                    // Final divide: acc still holds N * prod.
                    is_div_reg <= 1'b1;
                    shr_reg    <= acc_reg << (DW - NUM_K);
                    opd_reg    <= DW'({var_reg, 1'b0});
                end
            endcase
        end
        else if (state_reg == S_RUN)
        begin
            acc_reg <= acc_next;
            shr_reg <= shr_next;
        end
        else if (state_reg == S_NEXT)
        begin
            unique case (op_reg)
                OP_MU:   mu_reg   <= shr_reg[MU_W-1:0];
                OP_NN:   nn_reg   <= acc_reg[NN_W-1:0];
                OP_P1:   p1_reg   <= acc_reg[P_W-1:0];
                OP_VAR:  var_reg  <= var_clamped;
                OP_PROD: prod_reg <= acc_reg[PROD_W-1:0];
                default: ;
            endcase
        end
    end

    // Pair count always matches the sum of the bins.
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg == N_W'(bin_reg[0]) + N_W'(bin_reg[1]) + N_W'(bin_reg[2])
                 + N_W'(bin_reg[3]) + N_W'(bin_reg[4]))
        else $error("pair count out of step with bins");

    // The score sum never exceeds four half points per pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg <= {n_reg, 2'b00})
        else $error("score sum exceeds its bound");

    // A reached verdict is never changed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_verdict_reg != VERDICT_RUNNING) |=> (held_verdict_reg == $past(held_verdict_reg)))
        else $error("held verdict changed");

    // Multiply passes never overflow the accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && !is_div_reg) |-> (unit_y[DW+1:DW] == 2'b00))
        else $error("product overflow in shared unit");

    // Divide passes keep the partial remainder below a nonzero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && is_div_reg) |-> (opd_reg != '0 && acc_reg < opd_reg))
        else $error("divider remainder out of range");

endmodule
